/* hw/rtl/fdd_pkg.sv */
// ---------------------------------------------------------------------------
// fdd_pkg
// Shared types and constants of the finite-difference differentiator.
// ---------------------------------------------------------------------------
package fdd_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int OUT_BITS        = 32;
    localparam int CFG_DATA_BITS   = 32;
    localparam int CFG_IDX_BITS    = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_MODE = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_INV  = 1'b1;

    localparam logic [CFG_DATA_BITS-1:0] INV_RESET = 32'h0001_0000;

    // ceil(2^33 / 3): exact floor(x / 3) for x below 2^33
    localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

    typedef enum logic [1:0] {
        MODE_FWD2 = 2'd0,
        MODE_CEN3 = 2'd1,
        MODE_CEN5 = 2'd2,
        MODE_ZERO = 2'd3
    } t_mode;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_win_ctl;

endpackage

/* hw/rtl/fdd_cell.sv */
// ---------------------------------------------------------------------------
// fdd_cell
// One tap of the sample window: takes its neighbour's sample on a shift,
// returns to zero on a clear.
// ---------------------------------------------------------------------------
module fdd_cell
    import fdd_pkg::*;
#(
    parameter int W = SAMPLE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_win_ctl     i_ctl,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_ctl.clear) begin
            r_q <= '0;
        end else if (i_ctl.shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

/* hw/rtl/fdd_scale.sv */
// ---------------------------------------------------------------------------
// fdd_scale
// Three-stage scaler: |D| * inverse interval / (K * 2^16), rounded half up
// on the magnitude and clamped to 2^31. K is 1, 2 or 12 by stencil.
// ---------------------------------------------------------------------------
module fdd_scale
    import fdd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int MW = SAMPLE_BITS + 4
) (
    input  logic                     i_clk,
    input  logic [MW-1:0]            i_mag,
    input  logic                     i_neg,
    input  t_mode                    i_kind,
    input  logic [CFG_DATA_BITS-1:0] i_inv,
    output logic [OUT_BITS-1:0]      o_mag,
    output logic                     o_neg
);

    localparam int AW = MW + 16;
    localparam int CW = (AW > 36) ? AW : 36;
    localparam int NW = AW + 17;

    localparam logic [CW-1:0] LIM_K1  = CW'(36'h0_8000_0000);
    localparam logic [CW-1:0] LIM_K2  = CW'(36'h1_0000_0000);
    localparam logic [CW-1:0] LIM_K12 = CW'(36'h6_0000_0000);
    localparam logic [NW-1:0] RND_K1  = NW'(20'h0_8000);
    localparam logic [NW-1:0] RND_K2  = NW'(20'h1_0000);
    localparam logic [NW-1:0] RND_K12 = NW'(20'h6_0000);
    localparam logic [NW-1:0] X_LIM   = NW'(36'h0_8000_0000);
    localparam logic [NW-1:0] X3_LIM  = NW'(36'h1_8000_0000);

    // stage 1: partial products
    logic [AW-1:0] r_a;
    logic [AW-1:0] r_b;
    t_mode         r_kind1;
    logic          r_neg1;

    // stage 2: rounding sum and shift
    logic [32:0]   r_x;
    logic          r_ovf;
    t_mode         r_kind2;
    logic          r_neg2;

    // stage 3: divide by three and clamp
    logic [OUT_BITS-1:0] r_r;
    logic                r_neg3;

    logic [CW-1:0] a_ext;
    logic [CW-1:0] lim;
    logic [NW-1:0] rnd;
    logic [NW-1:0] sum;
    logic [NW-1:0] x_full;
    logic          sat;
    logic          x_ovf;
    logic [64:0]   prod;
    logic [31:0]   q;

    always_comb begin
        a_ext = CW'(r_a);
        case (r_kind1)
            MODE_CEN3: begin
                lim = LIM_K2;
                rnd = RND_K2;
            end
            MODE_CEN5: begin
                lim = LIM_K12;
                rnd = RND_K12;
            end
            default: begin
                lim = LIM_K1;
                rnd = RND_K1;
            end
        endcase
        sat = (a_ext >= lim);
        sum = NW'({r_a, 16'h0000}) + NW'(r_b) + rnd;
        case (r_kind1)
            MODE_CEN3: x_full = sum >> 17;
            MODE_CEN5: x_full = sum >> 18;
            default:   x_full = sum >> 16;
        endcase
        x_ovf = (r_kind1 == MODE_CEN5) ? (x_full >= X3_LIM) : (x_full > X_LIM);
    end

    always_comb begin
        prod = 65'(r_x) * 65'(RECIP3);
        q    = (r_kind2 == MODE_CEN5) ? prod[64:33] : r_x[31:0];
    end

    always_ff @(posedge i_clk) begin
        r_a     <= AW'(i_mag) * AW'(i_inv[31:16]);
        r_b     <= AW'(i_mag) * AW'(i_inv[15:0]);
        r_kind1 <= i_kind;
        r_neg1  <= i_neg;

        r_x     <= x_full[32:0];
        r_ovf   <= sat | x_ovf;
        r_kind2 <= r_kind1;
        r_neg2  <= r_neg1;

        r_r     <= r_ovf ? 32'h8000_0000 : q;
        r_neg3  <= r_neg2;
    end

    assign o_mag = r_r;
    assign o_neg = r_neg3;

endmodule

/* hw/rtl/finite_difference_differentiator.sv */
// A request is accepted only in the idle step; it then passes the difference step, the
// three registered stages of the scaler and the emit step, which gives up to three results,
// before the block takes the next request.
// Output stalls hold the block in its emit step.
// Reset (synchronous, active low) zeroes the sample window and count and
// restores stencil mode 0 and an inverse interval of 1.0.
// ---------------------------------------------------------------------------
// finite_difference_differentiator
// Streaming 2/3/5-point derivative (or zero mode) with Q16.16 scaling and saturation.
// ---------------------------------------------------------------------------
module finite_difference_differentiator
    import fdd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [TDATA_BITS-1:0]    s_axis_tdata,   // [SAMPLE_BITS-1:0] sample_value
    input  logic                     s_axis_tlast,   // is_last
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_BITS-1:0]      m_axis_tdata,   // [31:0] derivative
    output logic                     m_axis_tlast    // last_out
);

    localparam int SB = SAMPLE_BITS;
    localparam int DW = SB + 5;
    localparam int MW = SB + 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_SUM,
        ST_DIV,
        ST_EMIT
    } t_state;

    t_state                  r_state;
    t_mode                   r_mode;
    logic [CFG_DATA_BITS-1:0] r_inv;
    logic [2:0]              r_seen;
    logic [1:0]              r_cnt;
    logic                    r_first;
    logic                    r_m_tvalid;
    logic [OUT_BITS-1:0]     r_m_tdata;
    logic                    r_m_tlast;
    logic [SB-1:0]           r_cur;
    logic                    r_last_in;
    logic                    r_main;
    logic                    r_calc;
    logic [MW-1:0]           r_mag;
    logic                    r_neg;
    t_mode                   r_kind;

    logic [SB-1:0] win_d [4];
    logic [SB-1:0] win_q [4];
    t_win_ctl      win_ctl;

    logic [2:0]           ahead;
    logic [2:0]           back;
    logic                 has_main;
    logic                 n_calc;
    logic [1:0]           n_rest;
    logic [1:0]           n_cnt;
    logic [2:0]           n_seen;
    logic signed [DW-1:0] cur_e;
    logic signed [DW-1:0] w0_e;
    logic signed [DW-1:0] w1_e;
    logic signed [DW-1:0] w2_e;
    logic signed [DW-1:0] w3_e;
    logic signed [DW-1:0] d_sel;
    logic [DW-1:0]        d_abs;
    logic                 d_neg;
    logic [OUT_BITS-1:0]  sc_mag;
    logic                 sc_neg;
    logic [OUT_BITS-1:0]  res;
    logic [OUT_BITS-1:0]  n_data;
    logic                 out_free;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_FWD2;
            r_inv  <= INV_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_MODE: r_mode <= t_mode'(i_cfg_data[1:0]);
                CFG_IDX_INV:  r_inv  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sample window
    assign win_ctl.shift = (r_state == ST_DIFF) && !r_last_in;
    assign win_ctl.clear = (r_state == ST_DIFF) && r_last_in;

    for (genvar j = 0; j < 4; j++) begin : g_win
        if (j == 0) begin : g_head
            assign win_d[j] = r_cur;
        end else begin : g_tail
            assign win_d[j] = win_q[j-1];
        end
        fdd_cell #(
            .W (SB)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (win_ctl),
            .i_d     (win_d[j]),
            .o_q     (win_q[j])
        );
    end

    // stencil difference and result count
    always_comb begin
        case (r_mode)
            MODE_FWD2: begin
                ahead = 3'd1;
                back  = 3'd0;
            end
            MODE_CEN3: begin
                ahead = 3'd1;
                back  = 3'd1;
            end
            MODE_CEN5: begin
                ahead = 3'd2;
                back  = 3'd2;
            end
            default: begin
                ahead = 3'd0;
                back  = 3'd0;
            end
        endcase
        has_main = (r_seen >= ahead);
        n_calc   = has_main && ((r_seen - ahead) >= back) && (r_mode != MODE_ZERO);
        if (!r_last_in) begin
            n_rest = 2'd0;
        end else if (has_main) begin
            n_rest = ahead[1:0];
        end else begin
            n_rest = r_seen[1:0] + 2'd1;
        end
        n_cnt  = n_rest + {1'b0, has_main};
        n_seen = r_last_in ? 3'd0 : ((r_seen == 3'd7) ? r_seen : r_seen + 3'd1);

        cur_e = DW'($signed(r_cur));
        w0_e  = DW'($signed(win_q[0]));
        w1_e  = DW'($signed(win_q[1]));
        w2_e  = DW'($signed(win_q[2]));
        w3_e  = DW'($signed(win_q[3]));
        case (r_mode)
            MODE_CEN3: d_sel = cur_e - w1_e;
            MODE_CEN5: d_sel = ((w0_e - w2_e) <<< 3) - (cur_e - w3_e);
            default:   d_sel = cur_e - w0_e;
        endcase
        d_neg = d_sel[DW-1];
        d_abs = d_neg ? DW'(-d_sel) : DW'(d_sel);
    end

    fdd_scale #(
        .SAMPLE_BITS (SB)
    ) u_scale (
        .i_clk  (i_clk),
        .i_mag  (r_mag),
        .i_neg  (r_neg),
        .i_kind (r_kind),
        .i_inv  (r_inv),
        .o_mag  (sc_mag),
        .o_neg  (sc_neg)
    );

    // sign and saturate
    always_comb begin
        if (sc_neg) begin
            res = 32'd0 - sc_mag;
        end else if (sc_mag[OUT_BITS-1]) begin
            res = 32'h7FFF_FFFF;
        end else begin
            res = sc_mag;
        end
        n_data = (r_first && r_main && r_calc) ? res : '0;
    end

    assign out_free = !r_m_tvalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_seen     <= '0;
            r_cnt      <= '0;
            r_first    <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (r_state == ST_EMIT && r_cnt != 2'd0 && out_free) begin
                r_m_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    r_cnt   <= n_cnt;
                    r_first <= 1'b1;
                    r_seen  <= n_seen;
                    r_state <= ST_MUL;
                end
                ST_MUL: r_state <= ST_SUM;
                ST_SUM: r_state <= ST_DIV;
                ST_DIV: r_state <= ST_EMIT;
                ST_EMIT: begin
                    if (r_cnt == 2'd0) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_cnt      <= r_cnt - 2'd1;
                        r_first    <= 1'b0;
                        if (r_cnt == 2'd1) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end

        if (r_state == ST_IDLE && s_axis_tvalid) begin
            r_cur     <= s_axis_tdata[SB-1:0];
            r_last_in <= s_axis_tlast;
        end
        if (r_state == ST_DIFF) begin
            r_main <= has_main;
            r_calc <= n_calc;
            r_mag  <= d_abs[MW-1:0];
            r_neg  <= d_neg;
            r_kind <= r_mode;
        end
        if (r_state == ST_EMIT && r_cnt != 2'd0 && out_free) begin
            r_m_tdata <= n_data;
            r_m_tlast <= r_last_in && (r_cnt == 2'd1);
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tlast  = r_m_tlast;

endmodule

/* hw/rtl/fdd_checker.sv */
// ---------------------------------------------------------------------------
// fdd_checker
// Port-level checks of the differentiator, bound to the top level.
// ---------------------------------------------------------------------------
module fdd_checker
    import fdd_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     s_axis_tvalid,
    input logic                     s_axis_tready,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [OUT_BITS-1:0]      m_axis_tdata,
    input logic                     m_axis_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // one request at a time: busy straight after a request is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    // the closing result of a trace is always an edge zero
    a_last_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == '0)
        else $error("last result not zero");

    // no result straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind finite_difference_differentiator fdd_checker u_fdd_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives sample traces into the finite-difference differentiator under every
// stencil mode and a range of inverse intervals, predicts each derivative
// request in fixed point, and compares the output stream field by field.
// ---------------------------------------------------------------------------
module testbench
    import fdd_pkg::*;
;

    localparam int SAMPLE_W     = SAMPLE_BITS_DEF;
    localparam int DRAIN_CYCLES = 24;
    localparam int STALL_LIMIT  = 5000;
    localparam int PHASE_ITEMS  = 100;

    typedef struct packed {
        logic [OUT_BITS-1:0] deriv;
        logic                last;
    } t_deriv;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [SAMPLE_W-1:0]      s_axis_tdata = '0;   // [23:0] sample_value
    logic                     s_axis_tlast = 1'b0; // is_last
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0]      m_axis_tdata;        // [31:0] derivative
    logic                     m_axis_tlast;        // last_out

    // predictor state
    longint                   trace_window [4];
    int                       trace_count;
    t_mode                    cur_mode;
    logic [31:0]              cur_inv;
    t_deriv                   expected_derivs [$];

    int                       send_idle_pct = 0;
    int                       recv_idle_pct = 0;
    int                       mismatch_count = 0;
    int                       stall_cycles = 0;

    finite_difference_differentiator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("%0t ns: %s", $realtime, msg);
        end
    endtask

    // D * inv / (K * 2^16), round half away from zero, saturate to 32 bits
    function automatic logic [31:0] scale_difference(input longint diff,
                                                     input logic [63:0] divisor);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        neg = diff < 0;
        mag = neg ? 64'(-diff) : 64'(diff);
        hi  = 64'(cur_inv[31:16]);
        lo  = 64'(cur_inv[15:0]);
        a   = mag * hi;
        b   = mag * lo;
        if (a >= (divisor << 31)) begin
            r = 64'd1 << 31;
        end else begin
            r = ((a << 16) + b + (divisor << 15)) / (divisor << 16);
            if (r > (64'd1 << 31)) begin
                r = 64'd1 << 31;
            end
        end
        if (!neg) begin
            return (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
        end
        return ~r[31:0] + 32'd1;
    endfunction

    task automatic predict_derivatives(input logic signed [SAMPLE_W-1:0] sample,
                                       input logic last);
        longint      cur;
        int          ahead;
        int          back;
        int          rest;
        int          n;
        logic [31:0] val;
        t_deriv      res [4];
        cur = sample;
        n   = 0;
        case (cur_mode)
            MODE_FWD2: begin ahead = 1; back = 0; end
            MODE_CEN3: begin ahead = 1; back = 1; end
            MODE_CEN5: begin ahead = 2; back = 2; end
            default:   begin ahead = 0; back = 0; end
        endcase
        if (trace_count >= ahead) begin
            val = '0;
            if (trace_count - ahead >= back) begin
                case (cur_mode)
                    MODE_FWD2: val = scale_difference(cur - trace_window[0], 64'd1);
                    MODE_CEN3: val = scale_difference(cur - trace_window[1], 64'd2);
                    MODE_CEN5: val = scale_difference(
                        8 * (trace_window[0] - trace_window[2])
                        - (cur - trace_window[3]), 64'd12);
                    default:   val = '0;
                endcase
            end
            res[n] = '{deriv: val, last: 1'b0};
            n++;
        end
        if (last) begin
            rest = (trace_count >= ahead) ? ahead : trace_count + 1;
            for (int k = 0; k < rest; k++) begin
                res[n] = '{deriv: '0, last: 1'b0};
                n++;
            end
            if (n > 0) begin
                res[n-1].last = 1'b1;
            end
            for (int k = 0; k < 4; k++) begin
                trace_window[k] = 0;
            end
            trace_count = 0;
        end else begin
            trace_window[3] = trace_window[2];
            trace_window[2] = trace_window[1];
            trace_window[1] = trace_window[0];
            trace_window[0] = cur;
            if (trace_count < 7) begin
                trace_count++;
            end
        end
        for (int k = 0; k < n; k++) begin
            expected_derivs.push_back(res[k]);
        end
    endtask

    // one request; tvalid stays high afterwards so the next can follow at once
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample,
                               input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        s_axis_tlast  <= last;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        predict_derivatives(sample, last);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (expected_derivs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input t_mode mode, input logic [31:0] inv);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_MODE;
        i_cfg_data <= CFG_DATA_BITS'(mode);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_IDX_INV;
        i_cfg_data <= inv;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_mode = mode;
        cur_inv  = inv;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(9))
            0: v = {1'b0, {(SAMPLE_W-1){1'b1}}};
            1: v = {1'b1, {(SAMPLE_W-1){1'b0}}};
            2, 3: begin
                v = SAMPLE_W'($urandom_range(511));
                v = v - 256;
            end
            default: v = SAMPLE_W'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [31:0] random_inverse();
        case ($urandom_range(5))
            0: return 32'd1;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom_range(32'h0002_0000, 32'd1);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_reset_defaults;
        send_sample(24'sh7FFFFF, 1'b0);
        send_sample(-24'sh800000, 1'b0);
        send_sample(24'sd0, 1'b0);
        send_sample(-24'sd1, 1'b1);
    endtask

    task automatic test_five_point_saturation;
        configure(MODE_CEN5, 32'hFFFF_FFFF);
        send_sample(24'sh7FFFFF, 1'b0);
        send_sample(-24'sh800000, 1'b0);
        send_sample(24'sh7FFFFF, 1'b0);
        send_sample(-24'sh800000, 1'b0);
        send_sample(24'sh7FFFFF, 1'b1);
    endtask

    task automatic test_three_point;
        configure(MODE_CEN3, 32'h0001_8000);
        send_sample(-24'sh800000, 1'b0);
        send_sample(24'sh7FFFFF, 1'b0);
        send_sample(24'sd3, 1'b1);
    endtask

    task automatic test_zero_mode;
        configure(MODE_ZERO, INV_RESET);
        send_sample(24'sh123456, 1'b0);
        send_sample(-24'sd7, 1'b1);
    endtask

    task automatic test_zero_interval;
        configure(MODE_FWD2, 32'd0);
        send_sample(24'sh7FFFFF, 1'b0);
        send_sample(-24'sh800000, 1'b1);
    endtask

    task automatic test_short_traces;
        configure(MODE_CEN5, 32'd1);
        send_sample(24'sh55AA55, 1'b1);
        configure(MODE_CEN3, INV_RESET);
        send_sample(24'sd100, 1'b0);
        send_sample(-24'sd100, 1'b1);
    endtask

    // traces of random length; reconfiguration may fall mid-trace
    task automatic test_random_traces(input int s_pct, input int r_pct);
        int sent;
        int since_cfg;
        int trace_len;
        int pos;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent      = 0;
        since_cfg = 0;
        trace_len = 0;
        pos       = 0;
        while (sent < PHASE_ITEMS) begin
            if (since_cfg == 0) begin
                configure(t_mode'($urandom_range(3)), random_inverse());
                since_cfg = $urandom_range(35, 15);
            end
            if (pos == 0) begin
                trace_len = ($urandom_range(3) == 0) ? $urandom_range(3, 1)
                                                     : $urandom_range(12, 4);
            end
            pos++;
            send_sample(random_sample(), pos == trace_len);
            if (pos == trace_len) begin
                pos = 0;
            end
            sent++;
            since_cfg--;
        end
    endtask

    // result checking and receiver back-pressure
    always @(posedge i_clk) begin
        t_deriv want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_derivs.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h last %b",
                                          m_axis_tdata, m_axis_tlast));
            end else begin
                want = expected_derivs.pop_front();
                if (m_axis_tdata !== want.deriv) begin
                    report_mismatch($sformatf("derivative %h, wanted %h",
                                              m_axis_tdata, want.deriv));
                end
                if (m_axis_tlast !== want.last) begin
                    report_mismatch($sformatf("last %b, wanted %b",
                                              m_axis_tlast, want.last));
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < 4; k++) begin
            trace_window[k] = 0;
        end
        trace_count   = 0;
        cur_mode      = MODE_FWD2;
        cur_inv       = INV_RESET;
        send_idle_pct = 38;
        recv_idle_pct = 64;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_five_point_saturation();
        test_three_point();
        test_zero_mode();
        test_zero_interval();
        test_short_traces();
        test_random_traces(38, 64);
        test_random_traces(64, 38);
        test_random_traces(0, 0);

        drain();
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/fdd_pkg.sv
hw/rtl/fdd_cell.sv
hw/rtl/fdd_scale.sv
hw/rtl/finite_difference_differentiator.sv
hw/rtl/fdd_checker.sv
tb/testbench.sv
